// File: sv/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants of the I2C EEPROM transfer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  // Depth of the queue between front and engine.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input item kinds.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NOSTART = 2'd2,
    ST_NACK    = 2'd3
  } status_t;

  // Bus sequencer phases, one-hot.
  typedef enum logic [14:0] {
    PH_IDLE      = 15'h0001,
    PH_START     = 15'h0002,
    PH_DEVW      = 15'h0004,
    PH_ACK_DEVW  = 15'h0008,
    PH_ADDR      = 15'h0010,
    PH_ACK_ADDR  = 15'h0020,
    PH_DATA      = 15'h0040,
    PH_ACK_DATA  = 15'h0080,
    PH_RESTART   = 15'h0100,
    PH_DEVR      = 15'h0200,
    PH_ACK_DEVR  = 15'h0400,
    PH_RECV      = 15'h0800,
    PH_MACK      = 15'h1000,
    PH_STOP      = 15'h2000,
    PH_STOP_NACK = 15'h4000
  } phase_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    logic        is_tick;
    logic        rnw;
    logic [7:0]  dev_base;   // device byte with address bits 10:8, bit 0 clear
    logic [7:0]  addr_lo;
    logic [7:0]  value;
    logic [15:0] count;
    logic        sda;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/i2cee_front.sv
// ----------------------------------------------------------------------------
// i2cee_front
// Input side: accepts items, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_front import i2cee_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic        in_read_not_write,
  input  wire logic [7:0]  in_device_address,
  input  wire logic [10:0] in_memory_address,
  input  wire logic [7:0]  in_write_value,
  input  wire logic [15:0] in_read_count,
  input  wire logic        in_sda_in,
  output logic             q_valid,
  output entry_t           q_entry,
  input  wire logic        q_pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  entry_t            new_entry;
  logic              push;

  // Classify: fold address bits 10:8 into the device byte up front.
  always_comb begin
    new_entry.is_tick  = (in_kind == KIND_TICK);
    new_entry.rnw      = in_read_not_write;
    new_entry.dev_base = (in_device_address | {4'b0, in_memory_address[10:8], 1'b0})
                         & 8'hFE;
    new_entry.addr_lo  = in_memory_address[7:0];
    new_entry.value    = in_write_value;
    new_entry.count    = in_read_count;
    new_entry.sda      = in_sda_in;
  end

  assign in_ready = (cnt_r != CntW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_entry;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: sv/i2cee_engine.sv
// ----------------------------------------------------------------------------
// i2cee_engine
// Back side: bus sequencer, one item per unstalled cycle, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_engine import i2cee_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire entry_t      q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_byte_valid,
  output logic [7:0]       out_read_data,
  output logic             out_last_byte,
  output logic             out_done_res,
  output logic [1:0]       out_status
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  value_r, value_nxt;
  logic        dir_r, dir_nxt;
  logic [1:0]  lines_r, lines_nxt;      // {scl, sda}

  logic        out_valid_r, out_valid_nxt;
  logic        scl_r, sda_r, bvld_r, last_r, done_r;
  logic [7:0]  rdata_r;
  status_t     status_r;

  logic        fire, tick_fire;
  logic        byte_vld, last_b, done_b;
  logic [7:0]  rdata_b;
  status_t     status_b;
  logic        cur, sda, bit_b, nack;
  logic [7:0]  shifted;
  logic [3:0]  bit_inc;
  logic [15:0] left_dec;

  function automatic logic [7:0] enter_shift(phase_t p, logic [7:0] cur_shift,
                                             logic [7:0] dev, logic [7:0] addr,
                                             logic [7:0] val);
    logic [7:0] r;
    r = cur_shift;
    case (p)
      PH_DEVW: r = dev;
      PH_ADDR: r = addr;
      PH_DATA: r = val;
      PH_DEVR: r = dev | 8'h01;
      PH_RECV: r = 8'h00;
      default: r = cur_shift;
    endcase
    return r;
  endfunction

  function automatic phase_t ack_of(phase_t p);
    phase_t r;
    case (p)
      PH_DEVW: r = PH_ACK_DEVW;
      PH_ADDR: r = PH_ACK_ADDR;
      PH_DATA: r = PH_ACK_DATA;
      PH_DEVR: r = PH_ACK_DEVR;
      default: r = PH_IDLE;
    endcase
    return r;
  endfunction

  assign fire      = q_valid && (!q_entry.is_tick || !out_valid_r || out_ready);
  assign tick_fire = fire && q_entry.is_tick;
  assign q_pop     = fire;
  assign sda       = q_entry.sda;
  assign cur       = lines_r[0];

  always_comb begin
    phase_nxt   = phase_r;
    step_nxt    = step_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    dev_nxt     = dev_r;
    addr_nxt    = addr_r;
    value_nxt   = value_r;
    dir_nxt     = dir_r;
    lines_nxt   = lines_r;
    byte_vld    = 1'b0;
    rdata_b     = 8'h00;
    last_b      = 1'b0;
    done_b      = 1'b0;
    status_b    = ST_OK;
    shifted     = {shift_r[6:0], sda};
    bit_inc     = bit_cnt_r + 1'b1;
    bit_b       = 1'b0;
    nack        = (left_r <= 16'd1);
    left_dec    = (left_r != 16'd0) ? left_r - 1'b1 : left_r;

    if (fire && !q_entry.is_tick) begin
      // command: taken only while idle
      if (phase_r == PH_IDLE) begin
        dir_nxt     = q_entry.rnw;
        dev_nxt     = q_entry.dev_base;
        addr_nxt    = q_entry.addr_lo;
        value_nxt   = q_entry.value;
        left_nxt    = q_entry.count;
        bit_cnt_nxt = '0;
        shift_nxt   = '0;
        phase_nxt   = PH_START;
        step_nxt    = '0;
      end
    end else if (tick_fire) begin
      // Stage 1: decisions on the sample that move to a new phase
      // without driving the bus this interval.
      case (phase_r)
        PH_RESTART: begin
          if ((step_r == 2'd1 && !sda) || (step_r == 2'd2 && sda)) begin
            phase_nxt   = PH_DEVR;
            step_nxt    = '0;
            bit_cnt_nxt = '0;
            shift_nxt   = enter_shift(PH_DEVR, shift_r, dev_r, addr_r, value_r);
          end
        end
        PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DATA, PH_ACK_DEVR: begin
          if (step_r == 2'd3) begin
            case (phase_r)
              PH_ACK_DEVW: phase_nxt = sda ? PH_STOP_NACK : PH_ADDR;
              PH_ACK_ADDR: phase_nxt = dir_r ? PH_RESTART : PH_DATA;
              PH_ACK_DATA: phase_nxt = PH_STOP;
              default:     phase_nxt = (left_r != 16'd0) ? PH_RECV : PH_STOP;
            endcase
            step_nxt    = '0;
            bit_cnt_nxt = '0;
            shift_nxt   = enter_shift(phase_nxt, shift_r, dev_r, addr_r, value_r);
          end
        end
        PH_RECV: begin
          if (step_r == 2'd2) begin
            shift_nxt   = shifted;
            bit_cnt_nxt = bit_inc;
            step_nxt    = '0;
            if (bit_inc >= 4'd8) begin
              byte_vld    = 1'b1;
              rdata_b     = shifted;
              last_b      = (left_r == 16'd1);
              phase_nxt   = PH_MACK;
              bit_cnt_nxt = '0;
            end
          end
        end
        default: ;
      endcase

      // Stage 2: drive the bus for this interval.
      bit_b = shift_nxt[7];
      case (phase_nxt)
        PH_IDLE: ;
        PH_START, PH_RESTART: begin
          if (step_nxt == 2'd0) begin
            lines_nxt = 2'b11;
            step_nxt  = 2'd1;
          end else if (step_nxt == 2'd1) begin
            if (sda) begin
              lines_nxt = 2'b10;
              step_nxt  = 2'd2;
            end else begin
              done_b      = 1'b1;
              status_b    = ST_BUSY;
              phase_nxt   = PH_IDLE;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
            end
          end else if (step_nxt == 2'd2) begin
            if (!sda) begin
              lines_nxt   = 2'b10;
              phase_nxt   = (phase_nxt == PH_START) ? PH_DEVW : PH_DEVR;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
              shift_nxt   = enter_shift(phase_nxt, shift_nxt, dev_r, addr_r, value_r);
            end else begin
              done_b      = 1'b1;
              status_b    = ST_NOSTART;
              phase_nxt   = PH_IDLE;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
            end
          end
        end
        PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
          if (step_nxt == 2'd0) begin
            lines_nxt = {1'b0, cur};
            step_nxt  = 2'd1;
          end else if (step_nxt == 2'd1) begin
            lines_nxt = {1'b0, bit_b};
            step_nxt  = 2'd2;
          end else begin
            lines_nxt   = {1'b1, bit_b};
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            step_nxt    = '0;
            if (bit_inc >= 4'd8) begin
              phase_nxt   = ack_of(phase_nxt);
              bit_cnt_nxt = '0;
            end
          end
        end
        PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DATA, PH_ACK_DEVR: begin
          if (step_nxt == 2'd0) begin
            lines_nxt = {1'b0, cur};
            step_nxt  = 2'd1;
          end else if (step_nxt == 2'd1) begin
            lines_nxt = 2'b01;
            step_nxt  = 2'd2;
          end else begin
            lines_nxt = 2'b11;
            step_nxt  = 2'd3;
          end
        end
        PH_RECV: begin
          if (step_nxt == 2'd0) begin
            lines_nxt = 2'b01;
            step_nxt  = 2'd1;
          end else begin
            lines_nxt = 2'b11;
            step_nxt  = 2'd2;
          end
        end
        PH_MACK: begin
          case (step_nxt)
            2'd0: begin
              lines_nxt = {1'b0, cur};
              step_nxt  = 2'd1;
            end
            2'd1: begin
              lines_nxt = {1'b0, nack};
              step_nxt  = 2'd2;
            end
            2'd2: begin
              lines_nxt = {1'b1, nack};
              step_nxt  = 2'd3;
            end
            default: begin
              lines_nxt   = {1'b0, nack};
              left_nxt    = left_dec;
              phase_nxt   = (left_dec != 16'd0) ? PH_RECV : PH_STOP;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
              shift_nxt   = enter_shift(phase_nxt, shift_nxt, dev_r, addr_r, value_r);
            end
          endcase
        end
        PH_STOP, PH_STOP_NACK: begin
          case (step_nxt)
            2'd0: begin
              lines_nxt = {1'b0, cur};
              step_nxt  = 2'd1;
            end
            2'd1: begin
              lines_nxt = 2'b00;
              step_nxt  = 2'd2;
            end
            2'd2: begin
              lines_nxt = 2'b10;
              step_nxt  = 2'd3;
            end
            default: begin
              lines_nxt   = 2'b11;
              done_b      = 1'b1;
              status_b    = (phase_nxt == PH_STOP_NACK) ? ST_NACK : ST_OK;
              phase_nxt   = PH_IDLE;
              step_nxt    = '0;
              bit_cnt_nxt = '0;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_IDLE;
          step_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      left_r      <= '0;
      dev_r       <= '0;
      addr_r      <= '0;
      value_r     <= '0;
      dir_r       <= 1'b0;
      lines_r     <= 2'b11;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      left_r      <= left_nxt;
      dev_r       <= dev_nxt;
      addr_r      <= addr_nxt;
      value_r     <= value_nxt;
      dir_r       <= dir_nxt;
      lines_r     <= lines_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each tick
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      scl_r    <= lines_nxt[1];
      sda_r    <= lines_nxt[0];
      bvld_r   <= byte_vld;
      rdata_r  <= rdata_b;
      last_r   <= last_b;
      done_r   <= done_b;
      status_r <= status_b;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_out    = scl_r;
  assign out_sda_out    = sda_r;
  assign out_byte_valid = bvld_r;
  assign out_read_data  = rdata_r;
  assign out_last_byte  = last_r;
  assign out_done_res   = done_r;
  assign out_status     = status_r;

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !done_r) |-> status_r == ST_OK)
    else $error("status set without done");

  a_data_only_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !bvld_r) |-> (rdata_r == 8'h00 && !last_r))
    else $error("read data without byte");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < 4'd8)
    else $error("bit count out of range");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_fire && done_b) |=> phase_r == PH_IDLE)
    else $error("done without return to idle");

endmodule

`default_nettype wire

// File: sv/i2c_master_eeprom_transfer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_eeprom_transfer_top
// Open-drain I2C master for one-byte EEPROM writes and N-byte random reads.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | carries
//  --------+-----+---------------------+-----------------------------------
//  in_     | in  | in_valid/in_ready   | command (kind 0) or bus tick (kind 1)
//  out_    | out | out_valid/out_ready | SCL/SDA levels, read byte, done/status
//
// Rate: one item per clock while tick results are taken; a tick's result
//   is registered after the front queue. Commands produce no result.
// The front queue (QUEUE_DEPTH entries) separates acceptance from the engine.
// The engine handles one queued item per clock; a tick waits only while the
//   output register holds an untaken result.
// Reset (rst_n low, synchronous): sequencer idle, both lines released,
//   queue and output register empty.
// out_ready low stalls the engine at the next tick while a result is held;
//   in_ready drops once the queue fills behind it.
//
`default_nettype none

module i2c_master_eeprom_transfer_top import i2cee_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic        in_read_not_write,
  input  wire logic [7:0]  in_device_address,
  input  wire logic [10:0] in_memory_address,
  input  wire logic [7:0]  in_write_value,
  input  wire logic [15:0] in_read_count,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_byte_valid,
  output logic [7:0]       out_read_data,
  output logic             out_last_byte,
  output logic             out_done_res,
  output logic [1:0]       out_status
);

  // queue handoff between front and engine
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // front: classify each transaction and queue it
  i2cee_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_read_not_write (in_read_not_write),
    .in_device_address (in_device_address),
    .in_memory_address (in_memory_address),
    .in_write_value    (in_write_value),
    .in_read_count     (in_read_count),
    .in_sda_in         (in_sda_in),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .q_pop             (q_pop)
  );

  // engine: bus sequencer plus registered result
  i2cee_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_out    (out_scl_out),
    .out_sda_out    (out_sda_out),
    .out_byte_valid (out_byte_valid),
    .out_read_data  (out_read_data),
    .out_last_byte  (out_last_byte),
    .out_done_res   (out_done_res),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

// File: tb/sv/i2c_master_eeprom_transfer_top_test.sv
// ----------------------------------------------------------------------------
// i2c_master_eeprom_transfer_top_test
// Self-checking bench for the I2C EEPROM transfer engine. A short table of
// directed items covers idle ticks, field extremes and the start aborts.
// Random traffic follows: whole transactions against a modeled slave, with
// NACKs, failed restarts, bus-busy and noise mixed in. Every tick result is
// checked against a typed golden or the cycle-level bus sequencer model.
// ----------------------------------------------------------------------------
module i2c_master_eeprom_transfer_top_test;
  import i2cee_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int CALM_FIRST   = 700;    // no idling on either side in this span
  localparam int CALM_LAST    = 1000;
  localparam int IDLE_PCT     = 21;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;

  // One input transaction, as presented on the in_ ports.
  typedef struct packed {
    logic        kind;
    logic        rnw;
    logic [7:0]  dev;
    logic [10:0] addr;
    logic [7:0]  val;
    logic [15:0] cnt;
    logic        sda;
  } bus_item_t;

  // One output transaction, as seen on the out_ ports.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       byte_valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    status_t    status;
  } bus_result_t;

  // Directed row: golden result typed in where it is obvious.
  typedef struct packed {
    bus_item_t   item;
    logic        typed;
    bus_result_t golden;
  } plan_row_t;

  // How the modeled slave (and the bus around it) behaves for one transfer.
  typedef enum logic [2:0] {
    SLV_GOOD,         // acks everything
    SLV_BUSY,         // SDA held low before start
    SLV_NOSTART,      // SDA stays high after the start edge
    SLV_NACK_DEV,     // device byte not acknowledged
    SLV_RST_BUSY,     // restart finds SDA low
    SLV_RST_NOSTART,  // restart edge not seen
    SLV_SLOPPY        // random NACKs on the later acks
  } slave_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_TICK;
  logic        in_read_not_write = 1'b0;
  logic [7:0]  in_device_address = '0;
  logic [10:0] in_memory_address = '0;
  logic [7:0]  in_write_value = '0;
  logic [15:0] in_read_count = '0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_byte_valid;
  logic [7:0]  out_read_data;
  logic        out_last_byte;
  logic        out_done_res;
  logic [1:0]  out_status;

  i2c_master_eeprom_transfer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_read_not_write (in_read_not_write),
    .in_device_address (in_device_address),
    .in_memory_address (in_memory_address),
    .in_write_value    (in_write_value),
    .in_read_count     (in_read_count),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_out       (out_scl_out),
    .out_sda_out       (out_sda_out),
    .out_byte_valid    (out_byte_valid),
    .out_read_data     (out_read_data),
    .out_last_byte     (out_last_byte),
    .out_done_res      (out_done_res),
    .out_status        (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bus sequencer model: own copy of the engine state.
  // --------------------------------------------------------------------------
  phase_t      bus_phase = PH_IDLE;
  logic [2:0]  bus_step = '0;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] remaining = '0;
  logic [7:0]  dev_reg = '0;
  logic [10:0] addr_reg = '0;
  logic [7:0]  value_reg = '0;
  logic        rnw_reg = 1'b0;
  logic        scl_lvl = 1'b1;    // lines held between ticks
  logic        sda_lvl = 1'b1;
  bus_result_t bus_now;           // result of the tick being modeled

  bus_result_t due_bus_results[$];  // expected out_ transactions, oldest first
  plan_row_t   plan_rows[$];
  slave_mode_t slave_mode = SLV_GOOD;
  logic        calm = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bus_result_t head_result;

  // Drive both lines for this interval; the levels persist into idle ticks.
  task drive_lines(input logic scl, input logic sda);
    scl_lvl = scl;
    sda_lvl = sda;
    bus_now.scl = scl;
    bus_now.sda = sda;
  endtask

  // Phase entry loads the byte to shift; device byte carries addr[10:8] at 3:1.
  task enter_phase(input phase_t p);
    logic [7:0] dev_byte;
    dev_byte = dev_reg | {4'b0, addr_reg[10:8], 1'b0};
    bus_phase = p;
    bus_step = '0;
    bit_cnt = '0;
    case (p)
      PH_DEVW: shreg = dev_byte & 8'hFE;
      PH_ADDR: shreg = addr_reg[7:0];
      PH_DATA: shreg = value_reg;
      PH_DEVR: shreg = dev_byte | 8'h01;
      PH_RECV: shreg = '0;
      default: ;
    endcase
  endtask

  task end_transfer(input status_t st);
    bus_now.done = 1'b1;
    bus_now.status = st;
    bus_phase = PH_IDLE;
    bus_step = '0;
    bit_cnt = '0;
  endtask

  function automatic phase_t ack_after(input phase_t p);
    case (p)
      PH_DEVW: return PH_ACK_DEVW;
      PH_ADDR: return PH_ACK_ADDR;
      PH_DATA: return PH_ACK_DATA;
      default: return PH_ACK_DEVR;
    endcase
  endfunction

  // A command is taken only while the sequencer sits idle.
  task latch_command(input bus_item_t it);
    if (bus_phase == PH_IDLE) begin
      rnw_reg = it.rnw;
      dev_reg = it.dev;
      addr_reg = it.addr;
      value_reg = it.val;
      remaining = it.cnt;
      bit_cnt = '0;
      shreg = '0;
      bus_phase = PH_START;
      bus_step = '0;
    end
  endtask

  // One bus interval. Some phase changes fall through and act on the same tick
  // (failed restart, ack decisions, received bits), hence the loop.
  task step_bus_engine(input logic sda);
    logic   again;
    logic   ok;
    logic   cur;
    logic   nack;
    int     guard;
    phase_t p;
    phase_t nx;
    bus_now = '0;
    bus_now.status = ST_OK;
    bus_now.scl = scl_lvl;
    bus_now.sda = sda_lvl;
    again = 1'b1;
    guard = 0;
    while (again && guard < 6) begin
      again = 1'b0;
      guard++;
      p = bus_phase;
      cur = sda_lvl;
      case (p)
        PH_IDLE: ;
        PH_START, PH_RESTART: begin
          if (bus_step == 0) begin
            drive_lines(1'b1, 1'b1);
            bus_step = 3'd1;
          end else begin
            // step 1 wants a free bus, step 2 wants the start edge seen
            ok = (bus_step == 1) ? sda : !sda;
            if (!ok && p == PH_START) begin
              end_transfer(bus_step == 1 ? ST_BUSY : ST_NOSTART);
            end else if (!ok) begin
              // failed restart goes straight on with the read device byte
              enter_phase(PH_DEVR);
              again = 1'b1;
            end else begin
              drive_lines(1'b1, 1'b0);
              if (bus_step == 1) bus_step = 3'd2;
              else enter_phase(p == PH_START ? PH_DEVW : PH_DEVR);
            end
          end
        end
        PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
          if (bus_step == 0) begin
            drive_lines(1'b0, cur);
            bus_step = 3'd1;
          end else if (bus_step == 1) begin
            drive_lines(1'b0, shreg[7]);
            bus_step = 3'd2;
          end else begin
            drive_lines(1'b1, shreg[7]);
            shreg = {shreg[6:0], 1'b0};
            bit_cnt++;
            if (bit_cnt >= 8) enter_phase(ack_after(p));
            else bus_step = '0;
          end
        end
        PH_ACK_DEVW, PH_ACK_ADDR, PH_ACK_DATA, PH_ACK_DEVR: begin
          if (bus_step == 0) begin
            drive_lines(1'b0, cur);
            bus_step = 3'd1;
          end else if (bus_step == 1) begin
            drive_lines(1'b0, 1'b1);
            bus_step = 3'd2;
          end else if (bus_step == 2) begin
            drive_lines(1'b1, 1'b1);
            bus_step = 3'd3;
          end else begin
            // only the first device byte cares about a NACK
            if (p == PH_ACK_DEVW) nx = sda ? PH_STOP_NACK : PH_ADDR;
            else if (p == PH_ACK_ADDR) nx = rnw_reg ? PH_RESTART : PH_DATA;
            else if (p == PH_ACK_DATA) nx = PH_STOP;
            else nx = (remaining != 0) ? PH_RECV : PH_STOP;
            enter_phase(nx);
            again = 1'b1;
          end
        end
        PH_RECV: begin
          if (bus_step == 0) begin
            drive_lines(1'b0, 1'b1);
            bus_step = 3'd1;
          end else if (bus_step == 1) begin
            drive_lines(1'b1, 1'b1);
            bus_step = 3'd2;
          end else begin
            shreg = {shreg[6:0], sda};
            bit_cnt++;
            if (bit_cnt >= 8) begin
              bus_now.byte_valid = 1'b1;
              bus_now.data = shreg;
              bus_now.last = (remaining == 1);
              enter_phase(PH_MACK);
            end else begin
              bus_step = '0;
            end
            again = 1'b1;
          end
        end
        PH_MACK: begin
          nack = (remaining <= 1);
          if (bus_step == 0) begin
            drive_lines(1'b0, cur);
            bus_step = 3'd1;
          end else if (bus_step == 1) begin
            drive_lines(1'b0, nack);
            bus_step = 3'd2;
          end else if (bus_step == 2) begin
            drive_lines(1'b1, nack);
            bus_step = 3'd3;
          end else begin
            drive_lines(1'b0, nack);
            if (remaining != 0) remaining--;
            enter_phase(remaining != 0 ? PH_RECV : PH_STOP);
          end
        end
        PH_STOP, PH_STOP_NACK: begin
          if (bus_step == 0) begin
            drive_lines(1'b0, cur);
            bus_step = 3'd1;
          end else if (bus_step == 1) begin
            drive_lines(1'b0, 1'b0);
            bus_step = 3'd2;
          end else if (bus_step == 2) begin
            drive_lines(1'b1, 1'b0);
            bus_step = 3'd3;
          end else begin
            drive_lines(1'b1, 1'b1);
            end_transfer(p == PH_STOP_NACK ? ST_NACK : ST_OK);
          end
        end
        default: begin
          bus_phase = PH_IDLE;
          bus_step = '0;
        end
      endcase
    end
  endtask

  // Commands update the model; ticks queue one expected result each.
  task automatic take_item(input bus_item_t it, input logic typed, input bus_result_t golden);
    if (it.kind == KIND_CMD) begin
      latch_command(it);
    end else begin
      step_bus_engine(it.sda);
      due_bus_results.push_back(typed ? golden : bus_now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic plan_cmd(input logic rnw, input logic [7:0] dev, input logic [10:0] addr,
                          input logic [7:0] val, input logic [15:0] cnt);
    plan_row_t row;
    row = '0;
    row.item = {KIND_CMD, rnw, dev, addr, val, cnt, 1'b1};
    plan_rows.push_back(row);
  endtask

  task automatic plan_tick(input logic sda, input logic typed, input logic scl_e,
                           input logic sda_e, input logic done_e, input status_t st_e);
    plan_row_t row;
    row = '0;
    row.item.kind = KIND_TICK;
    row.item.sda = sda;
    row.typed = typed;
    row.golden.scl = scl_e;
    row.golden.sda = sda_e;
    row.golden.done = done_e;
    row.golden.status = st_e;
    plan_rows.push_back(row);
  endtask

  // Random command; large read counts only where the transfer aborts early.
  function automatic bus_item_t random_command(input slave_mode_t mode);
    bus_item_t it;
    it = '0;
    it.kind = KIND_CMD;
    it.rnw = (mode == SLV_RST_BUSY || mode == SLV_RST_NOSTART) ? 1'b1 : 1'($urandom_range(1));
    it.dev = 8'($urandom);
    it.addr = 11'($urandom_range(2047));
    it.val = 8'($urandom);
    it.sda = 1'($urandom_range(1));
    if (mode == SLV_BUSY || mode == SLV_NOSTART || mode == SLV_NACK_DEV)
      it.cnt = 16'($urandom_range(65535));
    else if ($urandom_range(9) == 0)
      it.cnt = 16'($urandom_range(8));
    else
      it.cnt = 16'($urandom_range(3));
    return it;
  endfunction

  // SDA level the slave and the bus leave for the next sample.
  function automatic logic slave_level();
    logic lvl;
    lvl = 1'($urandom_range(1));
    case (bus_phase)
      PH_START: begin
        if (bus_step == 1) lvl = (slave_mode != SLV_BUSY);
        else if (bus_step == 2) lvl = (slave_mode == SLV_NOSTART);
      end
      PH_RESTART: begin
        if (bus_step == 1) lvl = (slave_mode != SLV_RST_BUSY);
        else if (bus_step == 2) lvl = (slave_mode == SLV_RST_NOSTART);
      end
      PH_ACK_DEVW: if (bus_step == 3) lvl = (slave_mode == SLV_NACK_DEV);
      PH_ACK_ADDR, PH_ACK_DATA, PH_ACK_DEVR:
        if (bus_step == 3) lvl = (slave_mode == SLV_SLOPPY) ? 1'($urandom_range(1)) : 1'b0;
      default: ;
    endcase
    if ($urandom_range(99) < 3) lvl = !lvl;   // line glitch
    return lvl;
  endfunction

  // Random sender idling; valid drops only while nothing is pending.
  task automatic hold_off();
    int n;
    n = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) n++;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Put one transaction on in_ and wait for its handshake.
  task automatic present(input bus_item_t it);
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_read_not_write <= it.rnw;
    in_device_address <= it.dev;
    in_memory_address <= it.addr;
    in_write_value <= it.val;
    in_read_count <= it.cnt;
    in_sda_in <= it.sda;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // --------------------------------------------------------------------------
  // Sender: directed table, then random transfers, then the wind-down.
  // --------------------------------------------------------------------------
  initial begin : sender
    bus_item_t it;
    plan_row_t row;
    logic      counted;
    logic      first_cmd;
    int        n;
    int        pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // idle ticks right after reset: both lines released, no flags
    plan_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    plan_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    // all-ones command, bus found busy: abort without stop, lines held
    plan_cmd(1'b1, 8'hFF, 11'h7FF, 8'hFF, 16'hFFFF);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    plan_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ST_BUSY);
    plan_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    // all-zeros command, start edge never seen; command while busy is dropped
    plan_cmd(1'b0, 8'h00, 11'h000, 8'h00, 16'h0000);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    plan_cmd(1'b1, 8'hFF, 11'h7FF, 8'hFF, 16'hFFFF);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, ST_NOSTART);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    // good start into a write; the rest of it runs in the random part
    plan_cmd(1'b0, 8'hA5, 11'h5A3, 8'h3C, 16'h0001);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK);
    plan_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    plan_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
    repeat (6) plan_tick(1'($urandom_range(1)), 1'b0, 1'b0, 1'b0, 1'b0, ST_OK);

    while (plan_rows.size() != 0) begin
      row = plan_rows.pop_front();
      hold_off();
      present(row.item);
      take_item(row.item, row.typed, row.golden);
    end

    n = 0;
    first_cmd = 1'b1;
    while (n < RANDOM_ITEMS) begin
      counted = 1'b1;
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      it = '0;
      if (bus_phase == PH_IDLE && $urandom_range(99) >= 25) begin
        pick = $urandom_range(99);
        if (pick < 8) slave_mode = SLV_BUSY;
        else if (pick < 16) slave_mode = SLV_NOSTART;
        else if (pick < 30) slave_mode = SLV_NACK_DEV;
        else if (pick < 42) slave_mode = SLV_RST_BUSY;
        else if (pick < 54) slave_mode = SLV_RST_NOSTART;
        else if (pick < 66) slave_mode = SLV_SLOPPY;
        else slave_mode = SLV_GOOD;
        it = random_command(slave_mode);
        // now and then let every outstanding result drain before a new transfer
        if (first_cmd || $urandom_range(5) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (due_bus_results.size() != 0);
        end
        first_cmd = 1'b0;
      end else if (bus_phase != PH_IDLE && $urandom_range(99) < 3) begin
        it = random_command(SLV_GOOD);   // dropped by a busy engine
        counted = 1'b0;
      end else begin
        it.kind = KIND_TICK;
        it.sda = (bus_phase == PH_IDLE) ? 1'($urandom_range(1)) : slave_level();
      end
      hold_off();
      present(it);
      take_item(it, 1'b0, '0);
      if (counted) n++;
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (due_bus_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("i2c_master_eeprom_transfer_top_test: done, clean");
    end else begin
      $display("i2c_master_eeprom_transfer_top_test: done, errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, field-by-field check against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic compare_field(input string tag, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      if (due_bus_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual scl %0b sda %0b done %0b",
                 $time, out_scl_out, out_sda_out, out_done_res);
        mismatches++;
      end else begin
        head_result = due_bus_results.pop_front();
        compare_field("scl_out", head_result.scl, out_scl_out);
        compare_field("sda_out", head_result.sda, out_sda_out);
        compare_field("byte_valid", head_result.byte_valid, out_byte_valid);
        compare_field("read_data", head_result.data, out_read_data);
        compare_field("last_byte", head_result.last, out_last_byte);
        compare_field("done_res", head_result.done, out_done_res);
        compare_field("status", int'(head_result.status), out_status);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("i2c_master_eeprom_transfer_top_test: done, errors");
    $finish;
  end

endmodule

// File: i2c_master_eeprom_transfer_top.f
sv/i2cee_pkg.sv
sv/i2cee_front.sv
sv/i2cee_engine.sv
sv/i2c_master_eeprom_transfer_top.sv
tb/sv/i2c_master_eeprom_transfer_top_test.sv
